FILE: rtl/core/tone_note_sequencer_top_defines.svh
// assertion macros for the checker of the tone note sequencer
// depends on nothing; expects clk and rst_n in the scope of use
`ifndef TONE_NOTE_SEQUENCER_TOP_DEFINES_SVH
`define TONE_NOTE_SEQUENCER_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TNSEQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnseq check failed");

// condition holds in the cycle after the trigger
`define TNSEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnseq check failed");

`endif

FILE: rtl/core/tnseq_pkg.sv
// types, constants and state encoding for the tone note sequencer
// no dependencies; used by the top level and its checker
package tnseq_pkg;

  localparam int FREQ_W = 21;
  localparam int DUR_W  = 20;
  localparam int RATE_W = 10;
  localparam int DIV_W  = 16;
  localparam int PROD_W = DUR_W + RATE_W;

  localparam logic [FREQ_W-1:0] PIT_CLOCK_HZ    = 21'd1193180;
  localparam logic [FREQ_W-1:0] MIN_FREQ_HZ     = 21'd19;
  localparam logic [DUR_W-1:0]  MAX_DURATION_MS = 20'd600000;
  localparam logic [RATE_W-1:0] TICK_RATE_RESET = 10'd50;
  localparam logic [RATE_W:0]   MS_PER_SECOND   = 11'd1000;

  // iteration counts of the serial units
  localparam int MUL_STEPS  = RATE_W;
  localparam int TDIV_STEPS = DUR_W;
  localparam int FDIV_STEPS = FREQ_W;

  // function codes of an input transaction
  localparam logic FUNC_NOTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic              func;
    logic [FREQ_W-1:0] note_frequency;
    logic [DUR_W-1:0]  length_ms;
    logic              melody_end;
  } in_item_t;

  typedef struct packed {
    logic             gate_on;
    logic [DIV_W-1:0] tone_divisor;
    logic             param_error;
    logic             note_done;
    logic             melody_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } seq_state_t;

endpackage

FILE: rtl/core/tone_note_sequencer_top.sv
// tone note sequencer: note commands to tone divisor and gate, timed by ticks
// depends on tnseq_pkg
//
//  channel | ports                        | transfer
//  input   | in_valid in_ready in_data    | valid/ready, one transaction at a time
//  result  | out_valid out_ready out_data | valid/ready, output register
//  config  | cfg_we cfg_wdata             | write enable, no wait
//
// a tick or an invalid note skips the serial units: its result is registered, then emitted into the output register
// a valid note runs a 10-step shift-add multiply of duration by rate, a 20-step restoring
// divide by 1000 and a state update; the 21-step tone divide overlaps the first two
// input is ready again the cycle after the result moves to the output register; a stalled
// output register holds the result back and input with it
// reset is synchronous and leaves the gate off, tick rate 50
module tone_note_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tnseq_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tnseq_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  logic [tnseq_pkg::RATE_W-1:0] cfg_wdata
);
  import tnseq_pkg::*;

  localparam int CNT_W = $clog2(TDIV_STEPS);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(TDIV_STEPS - 1);
  localparam logic [CNT_W-1:0] FDIV_TAIL = CNT_W'(FDIV_STEPS - MUL_STEPS);

  seq_state_t state_r, state_nxt;

  // architectural state
  logic [RATE_W-1:0] rate_r;
  logic [DUR_W-1:0]  ticks_left_r, ticks_left_nxt;
  logic              playing_r, playing_nxt;
  logic              gate_r, gate_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic              last_r, last_nxt;
  out_item_t         res_r, res_nxt;

  // serial datapath
  logic [CNT_W-1:0]  cnt_r;
  logic [FREQ_W-1:0] freq_r;
  logic [DUR_W-1:0]  dur_r;
  logic              rest_r;
  logic              mend_r;
  logic [FREQ_W-1:0] dq_r;
  logic [FREQ_W-1:0] frem_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic accept, out_free, note_bad;
  logic mul_en, tdiv_en, fdiv_en, fin_en, emit_en;
  logic [FREQ_W:0]   frs, fdiff;
  logic              fge;
  logic [DUR_W:0]    msum;
  logic [RATE_W:0]   trs, tdiff;
  logic              tge;
  logic [RATE_W-1:0] trem;
  logic [DUR_W-1:0]  ticks_dec, ticks_new;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign note_bad = ((in_data.note_frequency != '0) &&
                     ((in_data.note_frequency < MIN_FREQ_HZ) ||
                      (in_data.note_frequency > PIT_CLOCK_HZ))) ||
                    (in_data.length_ms > MAX_DURATION_MS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_data.func == FUNC_NOTE) && !note_bad) state_nxt = ST_MUL;
          else state_nxt = ST_EMIT;
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    mul_en   = 1'b0;
    tdiv_en  = 1'b0;
    fdiv_en  = 1'b0;
    fin_en   = 1'b0;
    emit_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL: begin
        mul_en  = 1'b1;
        fdiv_en = 1'b1;
      end
      ST_DIV: begin
        tdiv_en = 1'b1;
        fdiv_en = (cnt_r < FDIV_TAIL);
      end
      ST_FIN:  fin_en  = 1'b1;
      ST_EMIT: emit_en = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // one restoring step of pit clock / frequency
  always_comb begin
    frs   = {frem_r, dq_r[FREQ_W-1]};
    fdiff = frs - {1'b0, freq_r};
    fge   = (frs >= {1'b0, freq_r});
  end

  // one shift-add step of duration * rate, multiplier bits in the low end
  assign msum = {1'b0, prod_r[PROD_W-1:RATE_W]} +
                (prod_r[0] ? {1'b0, dur_r} : {(DUR_W+1){1'b0}});

  // one restoring step of product / 1000, remainder in the high end
  always_comb begin
    trs   = {prod_r[PROD_W-1:DUR_W], prod_r[DUR_W-1]};
    tdiff = trs - MS_PER_SECOND;
    tge   = (trs >= MS_PER_SECOND);
    trem  = tge ? tdiff[RATE_W-1:0] : trs[RATE_W-1:0];
  end

  assign ticks_dec = (ticks_left_r == '0) ? '0 : ticks_left_r - DUR_W'(1);
  assign ticks_new = prod_r[DUR_W-1:0];

  // state update and pending result
  always_comb begin
    ticks_left_nxt = ticks_left_r;
    playing_nxt    = playing_r;
    gate_nxt       = gate_r;
    div_nxt        = div_r;
    last_nxt       = last_r;
    res_nxt        = res_r;
    if (accept) begin
      if (in_data.func == FUNC_TICK) begin
        res_nxt = '{gate_on: gate_r, tone_divisor: div_r, param_error: 1'b0,
                    note_done: 1'b0, melody_done: 1'b0};
        if (playing_r) begin
          ticks_left_nxt = ticks_dec;
          if (ticks_dec == '0) begin
            playing_nxt = 1'b0;
            gate_nxt    = 1'b0;
            res_nxt = '{gate_on: 1'b0, tone_divisor: div_r, param_error: 1'b0,
                        note_done: 1'b1, melody_done: last_r};
          end
        end
      end else if (note_bad) begin
        gate_nxt       = 1'b0;
        playing_nxt    = 1'b0;
        ticks_left_nxt = '0;
        last_nxt       = in_data.melody_end;
        res_nxt = '{gate_on: 1'b0, tone_divisor: div_r, param_error: 1'b1,
                    note_done: 1'b1, melody_done: in_data.melody_end};
      end
    end else if (fin_en) begin
      if (!rest_r) div_nxt = dq_r[DIV_W-1:0];
      last_nxt       = mend_r;
      ticks_left_nxt = ticks_new;
      if (ticks_new == '0) begin
        gate_nxt    = 1'b0;
        playing_nxt = 1'b0;
        res_nxt = '{gate_on: 1'b0, tone_divisor: div_nxt, param_error: 1'b0,
                    note_done: 1'b1, melody_done: mend_r};
      end else begin
        gate_nxt    = !rest_r;
        playing_nxt = 1'b1;
        res_nxt = '{gate_on: !rest_r, tone_divisor: div_nxt, param_error: 1'b0,
                    note_done: 1'b0, melody_done: 1'b0};
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rate_r       <= TICK_RATE_RESET;
      ticks_left_r <= '0;
      playing_r    <= 1'b0;
      gate_r       <= 1'b0;
      div_r        <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ticks_left_r <= ticks_left_nxt;
      playing_r    <= playing_nxt;
      gate_r       <= gate_nxt;
      div_r        <= div_nxt;
      last_r       <= last_nxt;
      if (cfg_we) rate_r <= cfg_wdata;
      if (emit_en) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // serial datapath and payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (emit_en) out_data_r <= res_r;
    if (accept) begin
      freq_r <= in_data.note_frequency;
      dur_r  <= in_data.length_ms;
      rest_r <= (in_data.note_frequency == '0);
      mend_r <= in_data.melody_end;
      dq_r   <= PIT_CLOCK_HZ;
      frem_r <= '0;
      prod_r <= {{DUR_W{1'b0}}, rate_r};
      cnt_r  <= '0;
    end else begin
      if (fdiv_en) begin
        frem_r <= fge ? fdiff[FREQ_W-1:0] : frs[FREQ_W-1:0];
        dq_r   <= {dq_r[FREQ_W-2:0], fge};
      end
      if (mul_en) begin
        prod_r <= {msum, prod_r[RATE_W-1:1]};
        cnt_r  <= (cnt_r == MUL_LAST) ? '0 : cnt_r + CNT_W'(1);
      end else if (tdiv_en) begin
        prod_r <= {trem, prod_r[DUR_W-2:0], tge};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/tnseq_checker.sv
// port-level checks for the tone note sequencer, bound to the top level
// depends on tnseq_pkg and tone_note_sequencer_top_defines.svh
`include "tone_note_sequencer_top_defines.svh"

module tnseq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input tnseq_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input tnseq_pkg::out_item_t out_data
);
  import tnseq_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && (in_data.func == FUNC_TICK || in_data.func == FUNC_NOTE);

  // a stalled result transaction holds
  `TNSEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // one transaction in flight at a time
  `TNSEQ_ASSERT_NEXT(a_one_in_flight, in_seen && in_ready, !in_ready)
  // a rejected note always finishes with the gate closed
  `TNSEQ_ASSERT_SAME(a_err_done, out_valid && out_data.param_error,
                     out_data.note_done && !out_data.gate_on)
  // melody end is only reported on a finished note, which closes the gate
  `TNSEQ_ASSERT_SAME(a_mdone_done, out_valid && out_data.melody_done,
                     out_data.note_done && !out_data.gate_on)

endmodule

bind tone_note_sequencer_top tnseq_checker u_tnseq_checker (.*);

FILE: bench/tone_note_sequencer_top_tb.sv
// self-checking bench for the tone note sequencer: directed notes, rests and ticks,
// then random melodies under several tick rates, checked against a cycle-free model
// depends on tnseq_pkg and tone_note_sequencer_top
module tone_note_sequencer_top_tb ();
  timeunit 1ns;
  timeprecision 1ps;
  import tnseq_pkg::*;

  localparam int RANDOM_ITEMS   = 1950;
  localparam int N_PHASES       = 7;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 6;
  localparam int MAX_SEQ_TICKS  = 18;

  // expected gate and divisor state, one entry per accepted transaction
  class tone_scoreboard;
    logic [RATE_W-1:0] tick_rate;
    logic [DUR_W-1:0]  ticks_left;
    logic [DIV_W-1:0]  divisor;
    bit                playing;
    bit                gate;
    bit                last_note;
    out_item_t         tone_states_due[$];
    int                errors;

    function new();
      tick_rate  = TICK_RATE_RESET;
      ticks_left = '0;
      divisor    = '0;
      playing    = 1'b0;
      gate       = 1'b0;
      last_note  = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return tone_states_due.size();
    endfunction

    // advance the sequencer state by one transaction and queue its outcome
    function void play_item(in_item_t item);
      out_item_t         tone;
      logic [PROD_W-1:0] prod;
      bit                bad;
      tone = '0;
      if (item.func == FUNC_TICK) begin
        if (playing) begin
          if (ticks_left != '0) ticks_left--;
          if (ticks_left == '0) begin
            playing          = 1'b0;
            gate             = 1'b0;
            tone.note_done   = 1'b1;
            tone.melody_done = last_note;
          end
        end
      end else begin
        bad = (item.note_frequency != '0 &&
               (item.note_frequency < MIN_FREQ_HZ || item.note_frequency > PIT_CLOCK_HZ)) ||
              item.length_ms > MAX_DURATION_MS;
        last_note = item.melody_end;
        if (bad) begin
          gate             = 1'b0;
          playing          = 1'b0;
          ticks_left       = '0;
          tone.param_error = 1'b1;
          tone.note_done   = 1'b1;
          tone.melody_done = item.melody_end;
        end else begin
          // tone loads a new divisor, rest keeps the old one
          if (item.note_frequency != '0) begin
            divisor = DIV_W'(PIT_CLOCK_HZ / item.note_frequency);
            gate    = 1'b1;
          end else begin
            gate = 1'b0;
          end
          prod       = PROD_W'(item.length_ms) * PROD_W'(tick_rate);
          ticks_left = DUR_W'(prod / MS_PER_SECOND);
          // zero-length countdown finishes on the spot
          if (ticks_left == '0) begin
            gate             = 1'b0;
            playing          = 1'b0;
            tone.note_done   = 1'b1;
            tone.melody_done = item.melody_end;
          end else begin
            playing = 1'b1;
          end
        end
      end
      tone.gate_on      = gate;
      tone.tone_divisor = divisor;
      tone_states_due.push_back(tone);
    endfunction

    function void report_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
      end
    endfunction

    // compare a delivered result with the oldest pending state
    function void check_tone(out_item_t got);
      out_item_t want;
      if (tone_states_due.size() == 0) begin
        errors++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = tone_states_due.pop_front();
      report_field("gate_on", 32'(want.gate_on), 32'(got.gate_on));
      report_field("tone_divisor", 32'(want.tone_divisor), 32'(got.tone_divisor));
      report_field("param_error", 32'(want.param_error), 32'(got.param_error));
      report_field("note_done", 32'(want.note_done), 32'(got.note_done));
      report_field("melody_done", 32'(want.melody_done), 32'(got.melody_done));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_we;
  logic [RATE_W-1:0] cfg_wdata;

  tone_scoreboard sb = new();
  bit             steady_flow = 1'b0;
  int             items_sent = 0;
  int             quiet_cycles = 0;

  always #6 clk = ~clk;

  tone_note_sequencer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.play_item(in_data);
      if (out_valid && out_ready) sb.check_tone(out_data);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tone_note_sequencer_top_tb NOT OK");
      $finish;
    end
  end

  // result side: random back-pressure per result
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic in_item_t note_cmd(logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur,
                                        logic mend);
    in_item_t item;
    item.func           = FUNC_NOTE;
    item.note_frequency = freq;
    item.length_ms      = dur;
    item.melody_end     = mend;
    return item;
  endfunction

  // ticks carry random junk in the unused fields
  function automatic in_item_t tick_cmd();
    in_item_t item;
    item.func           = FUNC_TICK;
    item.note_frequency = FREQ_W'($urandom_range(0, 2**FREQ_W - 1));
    item.length_ms      = DUR_W'($urandom_range(0, 2**DUR_W - 1));
    item.melody_end     = 1'($urandom_range(0, 1));
    return item;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t item;
    item.func           = $urandom_range(0, 1) ? FUNC_TICK : FUNC_NOTE;
    item.note_frequency = FREQ_W'($urandom_range(0, 2**FREQ_W - 1));
    item.length_ms      = DUR_W'($urandom_range(0, 2**DUR_W - 1));
    item.melody_end     = 1'($urandom_range(0, 1));
    return item;
  endfunction

  // mostly playable notes whose countdown a short run of ticks can finish
  function automatic in_item_t compose_note();
    int unsigned       kind;
    int unsigned       rate;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    rate = 32'(sb.tick_rate);
    if (rate == 0 || $urandom_range(0, 19) == 0) begin
      dur = DUR_W'($urandom_range(0, MAX_DURATION_MS));
    end else begin
      dur = DUR_W'($urandom_range(0, 16000 / rate));
    end
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      freq = '0;
    end else if (kind < 85) begin
      if ($urandom_range(0, 3) == 0) freq = FREQ_W'($urandom_range(MIN_FREQ_HZ, 4000));
      else freq = FREQ_W'($urandom_range(MIN_FREQ_HZ, PIT_CLOCK_HZ));
    end else begin
      freq = FREQ_W'($urandom_range(0, PIT_CLOCK_HZ));
      case ($urandom_range(0, 2))
        0: begin
          freq = FREQ_W'($urandom_range(1, MIN_FREQ_HZ - 1));
        end
        1: begin
          freq = FREQ_W'($urandom_range(PIT_CLOCK_HZ + 1, 2**FREQ_W - 1));
        end
        default: begin
          dur = DUR_W'($urandom_range(MAX_DURATION_MS + 1, 2**DUR_W - 1));
        end
      endcase
    end
    return note_cmd(freq, dur, 1'($urandom_range(0, 1)));
  endfunction

  // one transaction after a random gap; valid stays high into a back-to-back item
  task automatic send_item(in_item_t item);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  // hold off input until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] rate);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.tick_rate  = rate;
    @(posedge clk);
  endtask

  // a note followed by a run of ticks, now and then pure noise
  task automatic play_phrase();
    if ($urandom_range(0, 9) == 0) begin
      send_item(noise_item());
    end else begin
      send_item(compose_note());
      repeat ($urandom_range(0, MAX_SEQ_TICKS)) send_item(tick_cmd());
    end
    if ($urandom_range(0, 149) == 0) wait_drained();
  endtask

  // stimulus
  initial begin
    logic [RATE_W-1:0] phase_rates[N_PHASES];
    int                base;
    phase_rates = '{10'd1, 10'd1023, 10'd0, 10'd1000, 10'd7, 10'd50, 10'd0};
    phase_rates[N_PHASES-1] = RATE_W'($urandom_range(2, 999));

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_rate(TICK_RATE_RESET);

    // directed: idle tick, range edges, rest, zero-length, replacement while playing
    send_item(tick_cmd());
    send_item(note_cmd(MIN_FREQ_HZ, 20'd60, 1'b1));
    repeat (3) send_item(tick_cmd());
    send_item(note_cmd(PIT_CLOCK_HZ, 20'd20, 1'b0));
    send_item(tick_cmd());
    send_item(note_cmd('0, 20'd40, 1'b1));
    repeat (2) send_item(tick_cmd());
    send_item(note_cmd(FREQ_W'(MIN_FREQ_HZ - 1), 20'd100, 1'b0));
    send_item(note_cmd(21'd1, 20'd100, 1'b1));
    send_item(note_cmd(FREQ_W'(PIT_CLOCK_HZ + 1), 20'd100, 1'b0));
    send_item(note_cmd('1, '1, 1'b1));
    send_item(note_cmd('0, DUR_W'(MAX_DURATION_MS + 1), 1'b0));
    send_item(note_cmd(21'd440, MAX_DURATION_MS, 1'b0));
    send_item(tick_cmd());
    send_item(note_cmd(21'd1000, 20'd19, 1'b1));
    send_item(note_cmd('0, '0, 1'b0));
    send_item(note_cmd(21'd440, 20'd100, 1'b0));
    send_item(tick_cmd());
    send_item(note_cmd(21'd880, 20'd40, 1'b1));
    repeat (2) send_item(tick_cmd());
    send_item(tick_cmd());

    // random phases, each under its own tick rate, one without idling
    base = items_sent;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_rate(phase_rates[p]);
      steady_flow = (p == 3);
      while (items_sent < base + (p + 1) * (RANDOM_ITEMS / N_PHASES)) play_phrase();
    end
    steady_flow = 1'b0;

    // drain and settle
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tone_note_sequencer_top_tb OK");
    end else begin
      $display("tone_note_sequencer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
